@@ hdl/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reduction block.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rar_op_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_MULP = 9'b0_0000_0010,
    S_MULQ = 9'b0_0000_0100,
    S_MULD = 9'b0_0000_1000,
    S_SUM  = 9'b0_0001_0000,
    S_ABS  = 9'b0_0010_0000,
    S_GO   = 9'b0_0100_0000,
    S_RED  = 9'b0_1000_0000,
    S_FIN  = 9'b1_0000_0000
  } rar_top_state_t;

  typedef enum logic [7:0] {
    R_IDLE  = 8'b0000_0001,
    R_STRIP = 8'b0000_0010,
    R_XODD  = 8'b0000_0100,
    R_LOOP  = 8'b0000_1000,
    R_GSET  = 8'b0001_0000,
    R_DIVN  = 8'b0010_0000,
    R_DIVD  = 8'b0100_0000,
    R_DONE  = 8'b1000_0000
  } rar_red_state_t;

endpackage

@@ hdl/rar_in_if.sv @@
// ----------------------------------------------------------------------------
// rar_in_if
// Operand channel: operation code and two signed fractions.
// ----------------------------------------------------------------------------
interface rar_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ hdl/rar_out_if.sv @@
// ----------------------------------------------------------------------------
// rar_out_if
// Result channel: reduced numerator, denominator and status.
// ----------------------------------------------------------------------------
interface rar_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] res_num;
  logic [30:0]        res_den;
  logic               status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ hdl/rar_alu.sv @@
// ----------------------------------------------------------------------------
// rar_alu
// Shared subtract and compare unit: difference and borrow of two words.
// ----------------------------------------------------------------------------
module rar_alu import rar_pkg::*; #(
  parameter int WIDTH = 2 * OPERAND_WIDTH_DEF + 1
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ hdl/rar_reduce.sv @@
// ----------------------------------------------------------------------------
// rar_reduce
// Binary GCD of two magnitudes, then restoring division of both by the GCD,
// all on one shared subtractor.
// ----------------------------------------------------------------------------
module rar_reduce import rar_pkg::*; #(
  parameter int MW = 2 * OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] nmag,
  input  logic [MW-1:0] dmag,
  output logic          done,
  output logic [MW-1:0] qn,
  output logic [MW-1:0] qd
);

  localparam int AW = MW + 1;
  localparam int SW = $clog2(MW);
  localparam int CW = $clog2(MW);

  rar_red_state_t state_r, state_nxt;

  logic [MW-1:0] x_r, y_r, g_r, rem_r, quo_r, qn_r, qd_r;
  logic [SW-1:0] sh_r;
  logic [CW-1:0] cnt_r;

  logic [AW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_borrow;
  logic [MW-1:0] quo_step, rem_step;
  logic          cnt_last;

  rar_alu #(.WIDTH(AW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  always_comb begin
    if (state_r == R_LOOP) begin
      alu_a = {1'b0, y_r};
      alu_b = {1'b0, x_r};
    end else begin
      alu_a = {rem_r, quo_r[MW-1]};
      alu_b = {1'b0, g_r};
    end
  end

  assign quo_step = {quo_r[MW-2:0], ~alu_borrow};
  assign rem_step = alu_borrow ? {rem_r[MW-2:0], quo_r[MW-1]} : alu_diff[MW-1:0];
  assign cnt_last = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE:  if (start) state_nxt = (nmag == '0) ? R_GSET : R_STRIP;
      R_STRIP: if (x_r[0] | y_r[0]) state_nxt = R_XODD;
      R_XODD:  if (x_r[0]) state_nxt = R_LOOP;
      R_LOOP:  if (y_r == '0) state_nxt = R_GSET;
      R_GSET:  state_nxt = R_DIVN;
      R_DIVN:  if (cnt_last) state_nxt = R_DIVD;
      R_DIVD:  if (cnt_last) state_nxt = R_DONE;
      R_DONE:  state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        sh_r <= '0;
        if (nmag == '0) begin
          x_r <= dmag;
        end else begin
          x_r <= nmag;
        end
        y_r <= dmag;
      end
      R_STRIP: begin
        if (!(x_r[0] | y_r[0])) begin
          x_r  <= x_r >> 1;
          y_r  <= y_r >> 1;
          sh_r <= sh_r + 1'b1;
        end
      end
      R_XODD: begin
        if (!x_r[0]) x_r <= x_r >> 1;
      end
      R_LOOP: begin
        if (y_r != '0) begin
          if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (alu_borrow) begin
            x_r <= y_r;
            y_r <= x_r;
          end else begin
            y_r <= alu_diff[MW-1:0];
          end
        end
      end
      R_GSET: begin
        g_r   <= x_r << sh_r;
        quo_r <= nmag;
        rem_r <= '0;
        cnt_r <= CW'(MW - 1);
      end
      R_DIVN: begin
        if (cnt_last) begin
          qn_r  <= quo_step;
          quo_r <= dmag;
          rem_r <= '0;
          cnt_r <= CW'(MW - 1);
        end else begin
          cnt_r <= cnt_r - 1'b1;
          quo_r <= quo_step;
          rem_r <= rem_step;
        end
      end
      R_DIVD: begin
        cnt_r <= cnt_r - 1'b1;
        quo_r <= quo_step;
        rem_r <= rem_step;
        if (cnt_last) qd_r <= quo_step;
      end
      default: ;
    endcase
  end

  assign done = (state_r == R_DONE);
  assign qn   = qn_r;
  assign qd   = qd_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == R_IDLE)
    else $error("reduce started while busy");

  a_x_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == R_LOOP |-> x_r[0])
    else $error("even value in gcd subtract loop");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == R_DONE |-> qd_r != '0)
    else $error("reduced denominator is zero");

endmodule

@@ hdl/rational_arith_reduce.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Signed fraction add, subtract, multiply and divide with GCD reduction.
// ----------------------------------------------------------------------------
// Sequence: products and sign handling, then a binary GCD of one shift, swap or
//   subtract a cycle and two 2*OPERAND_WIDTH-bit restoring divisions; a zero
//   numerator skips the GCD loop and a zero denominator skips the reduction.
// Throughput: one item at a time, ready again in the cycle after the result
//   register loads; a held result stalls the input.
// Reset: synchronous, active low; clears the sequencers and the result valid.
// ----------------------------------------------------------------------------
module rational_arith_reduce import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rar_in_if.sink    in_if,
  rar_out_if.source out_if
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int NW = MW + 1;

  rar_top_state_t state_r, state_nxt;

  rar_op_t              op_r;
  logic signed [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [MW-1:0] p_r, q_r, d_r;
  logic signed [NW-1:0] num_r;
  logic [MW-1:0]        nmag_r, dmag_r;
  logic                 neg_r, zero_r;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [32:0]   out_num_r;
  logic [30:0]          out_den_r;
  logic                 out_status_r;

  logic                 in_fire, out_fire, out_load, red_start, red_done;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [MW-1:0] prod;
  logic signed [NW-1:0] p_ext, q_ext, sum_c, fin_num;
  logic [MW-1:0]        red_qn, red_qd;
  logic                 fin_neg;

  assign in_fire     = in_if.valid & in_if.ready;
  assign out_fire    = out_valid_r & out_if.ready;
  assign out_load    = (state_r == S_FIN) & (~out_valid_r | out_if.ready);
  assign red_start   = (state_r == S_GO);
  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      S_MULP: mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      S_MULQ: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      S_MULD: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_ext = NW'(p_r);
  assign q_ext = NW'(q_r);

  always_comb begin
    case (op_r)
      OP_ADD:  sum_c = p_ext + q_ext;
      OP_SUB:  sum_c = p_ext - q_ext;
      default: sum_c = p_ext;
    endcase
  end

  assign fin_neg = neg_r & (red_qn != '0);
  assign fin_num = fin_neg ? -$signed({1'b0, red_qn}) : $signed({1'b0, red_qn});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_MULP;
      S_MULP:  state_nxt = (op_r == OP_ADD || op_r == OP_SUB) ? S_MULQ : S_MULD;
      S_MULQ:  state_nxt = S_MULD;
      S_MULD:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_ABS;
      S_ABS:   state_nxt = (d_r == '0) ? S_FIN : S_GO;
      S_GO:    state_nxt = S_RED;
      S_RED:   if (red_done) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= rar_op_t'(in_if.operation);
      an_r <= in_if.a_num;
      ad_r <= in_if.a_den;
      bn_r <= in_if.b_num;
      bd_r <= in_if.b_den;
    end
    case (state_r)
      S_MULP: p_r <= prod;
      S_MULQ: q_r <= prod;
      S_MULD: d_r <= prod;
      S_SUM:  num_r <= sum_c;
      S_ABS: begin
        nmag_r <= num_r[NW-1] ? MW'(-num_r) : MW'(num_r);
        dmag_r <= d_r[MW-1] ? MW'(-d_r) : MW'(d_r);
        neg_r  <= num_r[NW-1] ^ d_r[MW-1];
        zero_r <= (d_r == '0);
      end
      default: ;
    endcase
    if (out_load) begin
      if (zero_r) begin
        out_num_r    <= 33'(num_r);
        out_den_r    <= '0;
        out_status_r <= 1'b1;
      end else begin
        out_num_r    <= 33'(fin_num);
        out_den_r    <= 31'(red_qd);
        out_status_r <= 1'b0;
      end
    end
  end

  rar_reduce #(.MW(MW)) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .nmag  (nmag_r),
    .dmag  (dmag_r),
    .done  (red_done),
    .qn    (red_qn),
    .qd    (red_qd)
  );

  assign out_if.valid   = out_valid_r;
  assign out_if.res_num = out_num_r;
  assign out_if.res_den = out_den_r;
  assign out_if.status  = out_status_r;

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_MULP)
    else $error("operand transfer did not start the product sequence");

  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    red_start |-> d_r != '0)
    else $error("reduction started on a zero denominator");

  a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_den_r == '0)
    else $error("error result with nonzero denominator");

endmodule
